FILE: rtl/core/bfpv_pkg.sv
`default_nettype none
package bfpv_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ZW = 33;              // cordic angle, Q.30
    localparam int XW = 34;              // cordic x / y, Q.30
    localparam int CW = 32;              // cos / sin fed to the multipliers

    localparam logic signed [XW-1:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [34:0]   PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0]   HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [16:0]   PI_Q12      = 17'sd12868;
    localparam logic signed [16:0]   TWO_PI_Q12  = 17'sd25736;

    localparam logic [15:0] GAIN_HORIZONTAL_RST = 16'd11796;
    localparam logic [15:0] GAIN_VERTICAL_RST   = 16'd26214;
    localparam logic [15:0] GAIN_HEADING_RST    = 16'd13107;

    typedef enum logic [1:0] {
        REG_GAIN_HORIZONTAL = 2'd0,
        REG_GAIN_VERTICAL   = 2'd1,
        REG_GAIN_HEADING    = 2'd2
    } cfg_reg_t;

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        logic signed [ZW-1:0] a;
        case (i)
            0:       a = 33'sd843314856;
            1:       a = 33'sd497837829;
            2:       a = 33'sd263043836;
            3:       a = 33'sd133525158;
            4:       a = 33'sd67021686;
            5:       a = 33'sd33543515;
            6:       a = 33'sd16775850;
            7:       a = 33'sd8388437;
            8:       a = 33'sd4194282;
            9:       a = 33'sd2097149;
            10:      a = 33'sd1048575;
            11:      a = 33'sd524287;
            12:      a = 33'sd262143;
            13:      a = 33'sd131071;
            14:      a = 33'sd65535;
            default: a = 33'sd32767;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bfpv_cordic.sv
`default_nettype none
module bfpv_cordic
    import bfpv_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic [CORDIC_STEPS-1:0]     ld,      // bit j loads iteration j
    input  wire logic signed [ZW-1:0]        z_in,
    output logic signed [XW-1:0]             x_out,
    output logic signed [XW-1:0]             y_out
);

    logic signed [XW-1:0] x_reg [CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS];

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN = atan_q30(j);
        logic signed [XW-1:0] xp, yp, x_next, y_next;
        logic signed [ZW-1:0] zp, z_next;

        if (j == 0) begin : g_first
            assign xp = CORDIC_K;
            assign yp = '0;
            assign zp = z_in;
        end else begin : g_rest
            assign xp = x_reg[j-1];
            assign yp = y_reg[j-1];
            assign zp = z_reg[j-1];
        end

        always_comb begin
            if (!zp[ZW-1]) begin
                x_next = xp - (yp >>> j);
                y_next = yp + (xp >>> j);
                z_next = zp - ATAN;
            end else begin
                x_next = xp + (yp >>> j);
                y_next = yp - (xp >>> j);
                z_next = zp + ATAN;
            end
        end

        always_ff @(posedge aclk) begin
            if (ld[j]) begin
                x_reg[j] <= x_next;
                y_reg[j] <= y_next;
                z_reg[j] <= z_next;
            end
        end
    end

    assign x_out = x_reg[CORDIC_STEPS-1];
    assign y_out = y_reg[CORDIC_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/core/body_frame_proportional_velocity_cmd_core.sv
// an accepted input beat passes through every pipeline stage, in order, to its output beat
// throughput: one beat per cycle; the 16 cordic iterations each own a stage
// and the multipliers are registered, so a new beat enters every unstalled cycle
// stalls hold every stage that is full; empty stages still fill under a stall
// reset (aresetn low, synchronous) empties the pipeline and loads the default gains
`default_nettype none
module body_frame_proportional_velocity_cmd_core
    import bfpv_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // pos_x, pos_y, pos_z, heading, target_x, target_y, target_z, target_heading
    input  wire logic [175:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // vel_forward, vel_lateral, vel_vertical, yaw_rate
    output logic [87:0]       m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int NS   = 21;
    localparam int LAST = CORDIC_STEPS;   // stage holding cordic result

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        if (v > 30'sd8388607)       return 24'sh7FFFFF;
        else if (v < -30'sd8388608) return 24'sh800000;
        else                        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767)       return 16'sh7FFF;
        else if (v < -18'sd32768) return 16'sh8000;
        else                      return v[15:0];
    endfunction

    // gains
    logic [15:0] gh_reg, gv_reg, gy_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gh_reg <= GAIN_HORIZONTAL_RST;
            gv_reg <= GAIN_VERTICAL_RST;
            gy_reg <= GAIN_HEADING_RST;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_GAIN_HORIZONTAL: gh_reg <= cfg_data;
                REG_GAIN_VERTICAL:   gv_reg <= cfg_data;
                REG_GAIN_HEADING:    gy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: a stage loads when empty or when the next one loads
    logic [NS-1:0] vld_reg;
    logic [NS:0]   ld;

    always_comb begin
        ld[NS] = m_tready;
        for (int i = NS - 1; i >= 0; i--) begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (ld[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 0: errors, heading range reduction, heading error wrap
    logic signed [23:0] px, py, pz, tx, ty, tz;
    logic signed [14:0] hd, th;
    logic signed [24:0] ex, ey, ez;
    logic signed [15:0] eh;
    logic signed [16:0] ew_next;
    logic signed [34:0] zf, zr;
    logic               neg;
    logic signed [ZW-1:0] z0_next;
    logic signed [25:0] exn_next, eyn_next;

    assign px = s_tdata[23:0];
    assign py = s_tdata[47:24];
    assign pz = s_tdata[71:48];
    assign hd = s_tdata[86:72];
    assign tx = s_tdata[110:87];
    assign ty = s_tdata[134:111];
    assign tz = s_tdata[158:135];
    assign th = s_tdata[173:159];

    always_comb begin
        ex = 25'(tx) - 25'(px);
        ey = 25'(ty) - 25'(py);
        ez = 25'(tz) - 25'(pz);
        zf = 35'(hd) <<< 18;
        neg = 1'b0;
        zr  = zf;
        if (zf > HALF_PI_Q30) begin
            zr  = zf - PI_Q30;
            neg = 1'b1;
        end else if (zf < -HALF_PI_Q30) begin
            zr  = zf + PI_Q30;
            neg = 1'b1;
        end
        z0_next = zr[ZW-1:0];
        // negating the errors stands in for negating cos and sin
        exn_next = neg ? -26'(ex) : 26'(ex);
        eyn_next = neg ? -26'(ey) : 26'(ey);
        eh = 16'(th) - 16'(hd);
        ew_next = 17'(eh);
        if (17'(eh) > PI_Q12)       ew_next = 17'(eh) - TWO_PI_Q12;
        else if (17'(eh) < -PI_Q12) ew_next = 17'(eh) + TWO_PI_Q12;
    end

    logic signed [ZW-1:0] z0_reg;
    logic signed [25:0]   exn_reg [LAST+1];
    logic signed [25:0]   eyn_reg [LAST+1];
    logic signed [24:0]   ez_reg  [LAST+1];
    logic signed [16:0]   ew_reg  [LAST+1];

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            z0_reg     <= z0_next;
            exn_reg[0] <= exn_next;
            eyn_reg[0] <= eyn_next;
            ez_reg[0]  <= ez;
            ew_reg[0]  <= ew_next;
        end
        for (int i = 1; i <= LAST; i++) begin
            if (ld[i]) begin
                exn_reg[i] <= exn_reg[i-1];
                eyn_reg[i] <= eyn_reg[i-1];
                ez_reg[i]  <= ez_reg[i-1];
                ew_reg[i]  <= ew_reg[i-1];
            end
        end
    end

    // stages 1..16: cosine and sine
    logic signed [XW-1:0] cx, sy;

    bfpv_cordic u_cordic (
        .aclk  (aclk),
        .ld    (ld[LAST:1]),
        .z_in  (z0_reg),
        .x_out (cx),
        .y_out (sy)
    );

    // stage 17: products
    logic signed [CW-1:0] c32, s32;
    logic signed [57:0]   pcx_reg, psy_reg, psx_reg, pcy_reg;
    logic signed [41:0]   pv_reg;
    logic signed [33:0]   py_reg;

    assign c32 = cx[CW-1:0];
    assign s32 = sy[CW-1:0];

    always_ff @(posedge aclk) begin
        if (ld[LAST+1]) begin
            pcx_reg <= c32 * exn_reg[LAST];
            psy_reg <= s32 * eyn_reg[LAST];
            psx_reg <= s32 * exn_reg[LAST];
            pcy_reg <= c32 * eyn_reg[LAST];
            pv_reg  <= ez_reg[LAST] * $signed({1'b0, gv_reg});
            py_reg  <= ew_reg[LAST] * $signed({1'b0, gy_reg});
        end
    end

    // stage 18: body-frame sums rounded to Q.16, vertical and yaw finished
    logic signed [58:0] fsum, lsum;
    logic signed [41:0] vsum;
    logic signed [33:0] ysum;
    logic signed [32:0] fr_reg, lr_reg;
    logic signed [23:0] vert_reg [3];
    logic signed [15:0] yaw_reg  [3];

    always_comb begin
        fsum = 59'(pcx_reg) + 59'(psy_reg) + 59'sd33554432;
        lsum = 59'(pcy_reg) - 59'(psx_reg) + 59'sd33554432;
        vsum = pv_reg + 42'sd32768;
        ysum = py_reg + 34'sd32768;
    end

    always_ff @(posedge aclk) begin
        if (ld[LAST+2]) begin
            fr_reg      <= fsum[58:26];
            lr_reg      <= lsum[58:26];
            vert_reg[0] <= sat24(30'($signed(vsum[41:16])));
            yaw_reg[0]  <= sat16(ysum[33:16]);
        end
    end

    // stage 19: horizontal gain
    logic signed [49:0] fg_reg, lg_reg;

    always_ff @(posedge aclk) begin
        if (ld[LAST+3]) begin
            fg_reg      <= fr_reg * $signed({1'b0, gh_reg});
            lg_reg      <= lr_reg * $signed({1'b0, gh_reg});
            vert_reg[1] <= vert_reg[0];
            yaw_reg[1]  <= yaw_reg[0];
        end
    end

    // stage 20: round to Q.12 and saturate, output beat
    logic signed [49:0] fgr, lgr;
    logic signed [23:0] fwd_reg, lat_reg;

    assign fgr = fg_reg + 50'sd524288;
    assign lgr = lg_reg + 50'sd524288;

    always_ff @(posedge aclk) begin
        if (ld[LAST+4]) begin
            fwd_reg     <= sat24(fgr[49:20]);
            lat_reg     <= sat24(lgr[49:20]);
            vert_reg[2] <= vert_reg[1];
            yaw_reg[2]  <= yaw_reg[1];
        end
    end

    assign m_tdata = {yaw_reg[2], vert_reg[2], lat_reg, fwd_reg};

endmodule
`default_nettype wire

FILE: tb/velocity_cmd_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module velocity_cmd_checker
    import bfpv_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [175:0] s_tdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [87:0]  m_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data,
    output int                fail_count,
    output int                pending
);

    // fields from the lowest bit up: vel_forward, vel_lateral, vel_vertical, yaw_rate
    typedef struct packed {
        logic signed [15:0] yaw_rate;
        logic signed [23:0] vel_vertical;
        logic signed [23:0] vel_lateral;
        logic signed [23:0] vel_forward;
    } vel_cmd_t;

    localparam longint ARCTAN_Q30 [16] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };
    localparam longint ROT_GAIN  = 652032874;
    localparam longint PI_30     = 64'sd3373259426;
    localparam longint HALF_PI_30 = 1686629713;
    localparam longint PI_12     = 12868;
    localparam longint TWO_PI_12 = 25736;

    logic [15:0] kp_horizontal, kp_vertical, kp_heading;
    vel_cmd_t    expected_cmds[$];

    assign pending = expected_cmds.size();

    function automatic longint round_shr(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic vel_cmd_t predict_cmd(input logic [175:0] d);
        logic signed [23:0] px, py, pz, tx, ty, tz;
        logic signed [14:0] hd, th;
        longint ex, ey, ez, z, x, y, nx, c, s, e, r16;
        bit flip;
        vel_cmd_t r;
        px = d[23:0];     py = d[47:24];    pz = d[71:48];    hd = d[86:72];
        tx = d[110:87];   ty = d[134:111];  tz = d[158:135];  th = d[173:159];
        ex = longint'(tx) - longint'(px);
        ey = longint'(ty) - longint'(py);
        ez = longint'(tz) - longint'(pz);
        // range-reduce by pi so the rotation stays within its domain
        z = longint'(hd) * 262144;
        flip = 0;
        if (z > HALF_PI_30) begin
            z = z - PI_30;
            flip = 1;
        end else if (z < -HALF_PI_30) begin
            z = z + PI_30;
            flip = 1;
        end
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN_Q30[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN_Q30[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        r16 = round_shr(c * ex + s * ey, 26);
        r.vel_forward = 24'(clamp(round_shr(r16 * longint'(kp_horizontal), 20), 24));
        r16 = round_shr(-s * ex + c * ey, 26);
        r.vel_lateral = 24'(clamp(round_shr(r16 * longint'(kp_horizontal), 20), 24));
        r.vel_vertical = 24'(clamp(round_shr(ez * longint'(kp_vertical), 16), 24));
        // heading error wraps once only
        e = longint'(th) - longint'(hd);
        if (e > PI_12)
            e = e - TWO_PI_12;
        else if (e < -PI_12)
            e = e + TWO_PI_12;
        r.yaw_rate = 16'(clamp(round_shr(e * longint'(kp_heading), 16), 16));
        return r;
    endfunction

    always @(posedge aclk) begin
        vel_cmd_t got, want;
        if (!aresetn) begin
            kp_horizontal <= GAIN_HORIZONTAL_RST;
            kp_vertical   <= GAIN_VERTICAL_RST;
            kp_heading    <= GAIN_HEADING_RST;
            expected_cmds.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN_HORIZONTAL: kp_horizontal <= cfg_data;
                    REG_GAIN_VERTICAL:   kp_vertical   <= cfg_data;
                    REG_GAIN_HEADING:    kp_heading    <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_cmds.size() == 0) begin
                    $error("output beat with nothing expected: %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_cmds.pop_front();
                    if (got.vel_forward !== want.vel_forward)
                        $error("vel_forward expected %0d got %0d",
                               want.vel_forward, got.vel_forward);
                    if (got.vel_lateral !== want.vel_lateral)
                        $error("vel_lateral expected %0d got %0d",
                               want.vel_lateral, got.vel_lateral);
                    if (got.vel_vertical !== want.vel_vertical)
                        $error("vel_vertical expected %0d got %0d",
                               want.vel_vertical, got.vel_vertical);
                    if (got.yaw_rate !== want.yaw_rate)
                        $error("yaw_rate expected %0d got %0d",
                               want.yaw_rate, got.yaw_rate);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (s_tvalid && s_tready)
                expected_cmds.push_back(predict_cmd(s_tdata));
        end
    end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import bfpv_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 300;
    localparam int DRAIN_WAIT = 30;

    logic         aclk;
    logic         aresetn;
    logic [175:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [87:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    int           fail_count;
    int           pending;
    int           idle_cycles;
    bit           hold_request;
    int           burst_left;

    body_frame_proportional_velocity_cmd_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    velocity_cmd_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 0;
    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // fields from the lowest bit up:
    // pos_x, pos_y, pos_z, heading, target_x, target_y, target_z, target_heading
    function automatic logic [175:0] pose_beat(
        input logic [23:0] px, input logic [23:0] py, input logic [23:0] pz,
        input logic [14:0] hd, input logic [23:0] tx, input logic [23:0] ty,
        input logic [23:0] tz, input logic [14:0] th);
        return {2'b00, th, tz, ty, tx, hd, pz, py, px};
    endfunction

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 24'h800000;
            1:       return 24'h7fffff;
            2:       return 24'h0;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [14:0] rand_heading();
        // mostly within [-pi, pi], some anywhere in the 15-bit range
        if ($urandom_range(0, 3) != 0)
            return 15'($urandom_range(0, 25736) - 12868);
        return 15'($urandom());
    endfunction

    function automatic logic [23:0] near_coord(input logic [23:0] p);
        return p + 24'($urandom_range(0, 65535) - 32768);
    endfunction

    function automatic logic [175:0] random_pose();
        logic [23:0] px, py, pz;
        px = rand_coord();
        py = rand_coord();
        pz = rand_coord();
        if ($urandom_range(0, 1))
            return pose_beat(px, py, pz, rand_heading(), near_coord(px), near_coord(py),
                             near_coord(pz), rand_heading());
        return pose_beat(px, py, pz, rand_heading(), rand_coord(), rand_coord(),
                         rand_coord(), rand_heading());
    endfunction

    task automatic send_pose(input logic [175:0] d);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // receiver: random stall patterns, plus one long hold on request
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(5, 60)) @(posedge aclk);
                    end
                    1: repeat ($urandom_range(5, 40)) begin
                        m_tready <= ($urandom_range(0, 3) != 0);
                        @(posedge aclk);
                    end
                    default: repeat ($urandom_range(2, 30)) begin
                        m_tready <= 1'($urandom_range(0, 1));
                        @(posedge aclk);
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("body_frame_proportional_velocity_cmd_core verification failed");
            $finish;
        end
    end

    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_valid    <= 1'b0;
        cfg_index    <= REG_GAIN_HORIZONTAL;
        cfg_data     <= '0;
        hold_request = 0;
        burst_left   = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, quadrant boundaries, heading wrap and its overflow
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'h0, 24'h0, 24'h0, 24'h0, 15'h0));
        send_pose(pose_beat(24'h800000, 24'h800000, 24'h800000, 15'h0,
                            24'h7fffff, 24'h7fffff, 24'h7fffff, 15'd12868));
        send_pose(pose_beat(24'h7fffff, 24'h7fffff, 24'h7fffff, 15'd6434,
                            24'h800000, 24'h800000, 24'h800000, -15'sd12868));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'd12868, 24'd4096, 24'd0, 24'd0, 15'd0));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, -15'sd12868, 24'd0, 24'd4096, 24'd0, 15'd0));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, -15'sd6434, 24'd4096, 24'd4096,
                            24'd0, 15'd12868));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'd6435, 24'd4096, 24'd0, 24'd0, 15'd0));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'h4000, 24'd8192, 24'd8192,
                            24'd4096, 15'h3fff));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'h3fff, 24'h800000, 24'h7fffff,
                            24'h1, 15'h4000));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, -15'sd12868, 24'd100, 24'd100,
                            24'd100, 15'd12868));
        send_pose(pose_beat(24'h0, 24'h0, 24'h0, 15'd12000, 24'd100, 24'hffff9c,
                            24'd1, -15'sd12000));
        send_pose(pose_beat(24'd1, 24'd1, 24'd1, 15'd1, 24'd0, 24'd0, 24'd0, 15'd0));
        send_pose(pose_beat(24'h7fffff, 24'h0, 24'h800000, 15'd3217,
                            24'h800000, 24'h7fffff, 24'h7fffff, -15'sd3217));
        send_pose(pose_beat(24'hffffff, 24'hffffff, 24'hffffff, 15'h7fff,
                            24'h0, 24'h0, 24'h0, 15'h0));
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    write_gain(REG_GAIN_HORIZONTAL, 16'h0000);
                    write_gain(REG_GAIN_VERTICAL, 16'h0000);
                    write_gain(REG_GAIN_HEADING, 16'h0000);
                end
                2: begin
                    write_gain(REG_GAIN_HORIZONTAL, 16'hffff);
                    write_gain(REG_GAIN_VERTICAL, 16'hffff);
                    write_gain(REG_GAIN_HEADING, 16'hffff);
                end
                3, 4: begin
                    write_gain(REG_GAIN_HORIZONTAL, 16'($urandom()));
                    write_gain(REG_GAIN_VERTICAL, 16'($urandom()));
                    write_gain(REG_GAIN_HEADING, 16'($urandom()));
                    write_gain(REG_UNMAPPED, 16'($urandom()));
                end
                default: ;
            endcase
            for (int n = 0; n < 250; n++) begin
                if (phase == 2 && n == 20)
                    hold_request = 1;
                send_pose(random_pose());
            end
            drain();
        end

        if (fail_count == 0)
            $display("body_frame_proportional_velocity_cmd_core verification clean");
        else
            $display("body_frame_proportional_velocity_cmd_core verification failed");
        $finish;
    end

endmodule
`default_nettype wire
